FILE: hdl/imusf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the imu sample scale and frame core
// no dependencies
package imusf_pkg;

	localparam int NUM_LANES   = 9;
	localparam int FRAME_WORDS = 20;
	localparam int LANE_LAT    = 12;

	localparam logic [4:0] LAST_IDX = 5'(FRAME_WORDS - 1);

	localparam logic [7:0] HDR0 = 8'h6B;
	localparam logic [7:0] HDR1 = 8'h6C;
	localparam logic [7:0] TRL0 = 8'h54;
	localparam logic [7:0] TRL1 = 8'h6F;
	localparam logic [7:0] TRL2 = 8'h43;
	localparam logic [7:0] TRL3 = 8'h41;

	localparam logic [7:0] CMD_RESET = 8'h01;

	// scale constants as integer mantissa and power-of-two exponent
	localparam logic [63:0] ACC_MANT  = 64'h0000_0000_009C_CCCD;
	localparam int          ACC_EXP   = -16;
	localparam logic [63:0] RATE_MANT = 64'h0000_0000_00FA_0000;
	localparam int          RATE_EXP  = -13;
	localparam logic [63:0] ANG_MANT  = 64'h0019_1EB8_51EB_851F;
	localparam int          ANG_EXP   = -51;

	// input field feeding each frame slot: rate z,x,y / angle z,x,y / accel y,x,z
	localparam int SLOT_FIELD [NUM_LANES] = '{5, 3, 4, 8, 6, 7, 1, 0, 2};

	typedef struct packed {
		logic [NUM_LANES-1:0][31:0] flt;
		logic [7:0]                 chk;
		logic [7:0]                 cmd;
	} frm_t;

endpackage

FILE: hdl/imusf_lane.sv
`timescale 1ns / 1ps
// one scaling lane: signed 16-bit reading to single float, 12 register stages
// depends on imusf_pkg
module imusf_lane #(
	parameter int          W    = 24,
	parameter logic [63:0] C    = 64'h9CCCCD,
	parameter int          CEXP = -16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] raw,
	output logic [31:0]        flt
);
	import imusf_pkg::*;

	localparam int LO   = (W + 1) / 2;
	localparam int HI   = W - LO;
	localparam int PW   = W + 17;
	localparam int NDIG = 5;
	localparam int NW   = NDIG * 15;
	localparam int DROP = W - 24;
	localparam logic [LO-1:0] C_LO = C[LO-1:0];
	localparam logic [HI-1:0] C_HI = C[W-1:LO];
	localparam logic signed [9:0] CE = 10'(CEXP + 16);
	localparam logic [15:0] DIVISOR = 16'h7FFF;

	// stage 1: sign and magnitude
	logic        sgn_s1, zero_s1;
	logic [16:0] mag_s1;
	logic [16:0] ext;
	assign ext = {raw[15], raw};

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= raw[15];
			zero_s1 <= (raw == 16'sd0);
			mag_s1  <= raw[15] ? 17'(17'd0 - ext) : ext;
		end
	end

	// stage 2: normalize
	logic [4:0] sh;
	always_comb begin
		sh = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (mag_s1[i])
				sh = 5'(16 - i);
		end
	end

	logic              sgn_s2, zero_s2;
	logic [16:0]       norm_s2;
	logic signed [9:0] ex_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s2  <= sgn_s1;
			zero_s2 <= zero_s1;
			norm_s2 <= mag_s1 << sh;
			ex_s2   <= 10'sd0 - $signed({5'd0, sh});
		end
	end

	// stage 3: partial products
	logic              sgn_s3, zero_s3;
	logic [16+HI:0]    pph_s3;
	logic [16+LO:0]    ppl_s3;
	logic signed [9:0] ex_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3  <= sgn_s2;
			zero_s3 <= zero_s2;
			pph_s3  <= norm_s2 * C_HI;
			ppl_s3  <= norm_s2 * C_LO;
			ex_s3   <= ex_s2;
		end
	end

	// stage 4: product sum
	logic              sgn_s4, zero_s4;
	logic [PW-1:0]     prod_s4;
	logic signed [9:0] ex_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s4  <= sgn_s3;
			zero_s4 <= zero_s3;
			prod_s4 <= {pph_s3, {LO{1'b0}}} + PW'(ppl_s3);
			ex_s4   <= ex_s3;
		end
	end

	// stage 5: round product to W bits
	logic [W-1:0] pm;
	logic         pg, pst, pt;
	logic [W:0]   psum;

	always_comb begin
		if (prod_s4[PW-1]) begin
			pm  = prod_s4[PW-1 -: W];
			pg  = prod_s4[16];
			pst = |prod_s4[15:0];
			pt  = 1'b1;
		end else begin
			pm  = prod_s4[PW-2 -: W];
			pg  = prod_s4[15];
			pst = |prod_s4[14:0];
			pt  = 1'b0;
		end
		psum = {1'b0, pm} + (W+1)'(pg & (pst | pm[0]));
	end

	logic              sgn_s5, zero_s5;
	logic [W-1:0]      m1_s5;
	logic signed [9:0] ex_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s5  <= sgn_s4;
			zero_s5 <= zero_s4;
			m1_s5   <= psum[W] ? {1'b1, {(W-1){1'b0}}} : psum[W-1:0];
			ex_s5   <= ex_s4 + CE + $signed({9'd0, pt}) + $signed({9'd0, psum[W]});
		end
	end

	// stages 6..10: long division by 32767, one 15-bit digit per stage
	logic              sgn_s  [NDIG];
	logic              zero_s [NDIG];
	logic signed [9:0] ex_s   [NDIG];
	logic [14:0]       rem_s  [NDIG];
	logic [NW-1:0]     num_s  [NDIG];
	logic [NW-1:0]     quo_s  [NDIG];

	for (genvar k = 0; k < NDIG; k++) begin : g_div
		logic              sgn_in, zero_in;
		logic signed [9:0] ex_in;
		logic [14:0]       rem_in;
		logic [NW-1:0]     num_in, quo_in;
		logic [15:0]       dsum;
		logic              dk;

		if (k == 0) begin : g_first
			assign sgn_in  = sgn_s5;
			assign zero_in = zero_s5;
			assign ex_in   = ex_s5;
			assign rem_in  = 15'd0;
			assign num_in  = NW'({m1_s5, 17'd0});
			assign quo_in  = '0;
		end else begin : g_next
			assign sgn_in  = sgn_s[k-1];
			assign zero_in = zero_s[k-1];
			assign ex_in   = ex_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign num_in  = num_s[k-1];
			assign quo_in  = quo_s[k-1];
		end

		assign dsum = {1'b0, rem_in} + {1'b0, num_in[NW-1 -: 15]};
		assign dk   = (dsum >= DIVISOR);

		always_ff @(posedge clk) begin
			if (en) begin
				sgn_s[k]  <= sgn_in;
				zero_s[k] <= zero_in;
				ex_s[k]   <= ex_in;
				rem_s[k]  <= dk ? 15'(dsum - DIVISOR) : dsum[14:0];
				num_s[k]  <= num_in << 15;
				quo_s[k]  <= {quo_in[NW-16:0], 15'(rem_in + 15'(dk))};
			end
		end
	end

	// stage 11: round quotient to W bits
	logic [NW-1:0] q;
	logic [W-1:0]  qm;
	logic          qg, qst, qu;
	logic [W:0]    qsum;

	always_comb begin
		q = quo_s[NDIG-1];
		if (q[W+2]) begin
			qm  = q[W+2:3];
			qg  = q[2];
			qst = (|q[1:0]) | (rem_s[NDIG-1] != 15'd0);
			qu  = 1'b1;
		end else begin
			qm  = q[W+1:2];
			qg  = q[1];
			qst = q[0] | (rem_s[NDIG-1] != 15'd0);
			qu  = 1'b0;
		end
		qsum = {1'b0, qm} + (W+1)'(qg & (qst | qm[0]));
	end

	logic              sgn_s11, zero_s11;
	logic [W-1:0]      m2_s11;
	logic signed [9:0] ex_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s11  <= sgn_s[NDIG-1];
			zero_s11 <= zero_s[NDIG-1];
			m2_s11   <= qsum[W] ? {1'b1, {(W-1){1'b0}}} : qsum[W-1:0];
			ex_s11   <= ex_s[NDIG-1] - 10'sd15 + $signed({9'd0, qu})
			            + $signed({9'd0, qsum[W]});
		end
	end

	// stage 12: round to single and pack
	logic [23:0]       fm;
	logic signed [9:0] fex;
	logic [9:0]        bexp;

	if (DROP > 0) begin : g_narrow
		logic       fg, fst;
		logic [24:0] fsum;
		always_comb begin
			fg   = m2_s11[DROP-1];
			fst  = |m2_s11[DROP-2:0];
			fsum = {1'b0, m2_s11[W-1 -: 24]} + 25'(fg & (fst | m2_s11[DROP]));
			fm   = fsum[24] ? 24'h800000 : fsum[23:0];
			fex  = ex_s11 + 10'(DROP) + $signed({9'd0, fsum[24]});
		end
	end else begin : g_keep
		assign fm  = 24'(m2_s11);
		assign fex = ex_s11;
	end

	assign bexp = 10'(fex + 10'sd150);

	always_ff @(posedge clk) begin
		if (en)
			flt <= zero_s11 ? 32'd0 : {sgn_s11, bexp[7:0], fm[22:0]};
	end

endmodule

FILE: hdl/imusf_framer.sv
`timescale 1ns / 1ps
// frame buffer and word serializer: one 80-byte frame out as twenty words
// depends on imusf_pkg
module imusf_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ld_valid,
	output logic                 ld_ready,
	input  imusf_pkg::frm_t      ld_frm,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,
	output logic                 m_tlast
);
	import imusf_pkg::*;

	frm_t       frm_q;
	logic [4:0] cnt_q;
	logic       busy_q;
	logic [31:0] word;

	assign ld_ready = !busy_q || (m_tready && cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (ld_valid && ld_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd0;
		end else if (busy_q && m_tready) begin
			if (cnt_q == LAST_IDX)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready)
			frm_q <= ld_frm;
	end

	always_comb begin
		word = 32'd0;
		if (cnt_q == 5'd0)
			word = {frm_q.cmd, frm_q.chk, HDR1, HDR0};
		else if (cnt_q == LAST_IDX)
			word = {TRL3, TRL2, TRL1, TRL0};
		else if (cnt_q <= 5'(NUM_LANES))
			word = frm_q.flt[4'(cnt_q - 5'd1)];
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {3'd0, cnt_q, word};
	assign m_tlast  = (cnt_q == LAST_IDX);

endmodule

FILE: hdl/imu_sample_scale_and_frame_core.sv
`timescale 1ns / 1ps
// top level: nine scaling lanes, checksum stages and frame serializer
// depends on imusf_pkg, imusf_lane, imusf_framer
//
// Each input transaction carries nine raw 16-bit readings and yields one 80-byte frame sent
// as twenty 32-bit words, one word per cycle while m_tready is high. The scaling pipeline
// is 14 register stages deep (12 in each float lane, two for the checksum) and takes a new
// transaction every cycle as long as its last stage can hand over; the word serializer,
// which sends all twenty words of one frame before it takes the next, sets the sustained
// rate. The command byte resets to 1 and may be rewritten through cfg_wen while the block
// is idle.
module imu_sample_scale_and_frame_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel x,y,z, rate x,y,z, angle x,y,z, 16 bits each from bit 0 up
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// frame_word [31:0], word_index [36:32], zero fill [39:37]
	output logic [39:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_wen,
	input  logic [7:0]   cfg_wdata
);
	import imusf_pkg::*;

	localparam int PIPE = LANE_LAT + 2;

	logic [7:0]            cmd_q;
	logic [PIPE-1:0]       vld_s;
	logic                  en;
	logic                  ld_ready;
	logic [31:0]           lane_flt [NUM_LANES];
	logic [31:0]           flt_s13  [NUM_LANES];
	logic [7:0]            bsum_s13 [NUM_LANES];
	frm_t                  frm_s14;
	logic [7:0]            chk;

	assign en       = !vld_s[PIPE-1] || ld_ready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmd_q <= CMD_RESET;
		else if (cfg_wen)
			cmd_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE-2:0], s_tvalid};
	end

	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		localparam int F = SLOT_FIELD[j];
		if (j < 3) begin : g_rate
			imusf_lane #(.W(24), .C(RATE_MANT), .CEXP(RATE_EXP)) u_lane (
				.clk(clk), .en(en), .raw(s_tdata[F*16 +: 16]), .flt(lane_flt[j])
			);
		end else if (j < 6) begin : g_ang
			imusf_lane #(.W(53), .C(ANG_MANT), .CEXP(ANG_EXP)) u_lane (
				.clk(clk), .en(en), .raw(s_tdata[F*16 +: 16]), .flt(lane_flt[j])
			);
		end else begin : g_acc
			imusf_lane #(.W(24), .C(ACC_MANT), .CEXP(ACC_EXP)) u_lane (
				.clk(clk), .en(en), .raw(s_tdata[F*16 +: 16]), .flt(lane_flt[j])
			);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flt_s13[j]  <= lane_flt[j];
				bsum_s13[j] <= lane_flt[j][7:0] + lane_flt[j][15:8]
				               + lane_flt[j][23:16] + lane_flt[j][31:24];
			end
		end
	end

	always_comb begin
		chk = cmd_q;
		for (int i = 0; i < NUM_LANES; i++)
			chk = chk + bsum_s13[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++)
				frm_s14.flt[i] <= flt_s13[i];
			frm_s14.chk <= chk;
			frm_s14.cmd <= cmd_q;
		end
	end

	imusf_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (vld_s[PIPE-1]),
		.ld_ready (ld_ready),
		.ld_frm   (frm_s14),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hdl/imusf_checker.sv
`timescale 1ns / 1ps
// port-level checks on the frame output stream, bound to the top level
// depends on imu_sample_scale_and_frame_core
module imusf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [39:0]  m_tdata,
	input logic         m_tlast
);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[36:32] == 5'd19)))
		else $error("tlast does not match word index");

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[36:32] == 5'd0) |-> (m_tdata[15:0] == 16'h6C6B))
		else $error("frame header missing");

	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && m_tdata[36:32] == $past(m_tdata[36:32]) + 5'd1))
		else $error("word index skipped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled transaction changed");

endmodule

bind imu_sample_scale_and_frame_core imusf_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for imu_sample_scale_and_frame_core: sends raw imu readings and
// checks every framed output word against a local float scaler and frame builder
// depends on imusf_pkg and the core rtl
module tb_top;
	import imusf_pkg::*;

	localparam logic [31:0] ACCEL_GAIN_SGL = 32'h411CCCCD; // 9.8 as single
	localparam int          STALL_LIMIT    = 3000;

	typedef logic signed [15:0] reading_t [NUM_LANES];

	typedef struct {
		logic [31:0] word;
		logic [4:0]  idx;
		logic        last;
	} frame_word_t;

	typedef struct {
		reading_t raw;
		bit       zero_frame;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_wen = 1'b0;
	logic [7:0]   cfg_wdata = '0;

	frame_word_t  frame_q [$];
	logic [7:0]   cmd_model = CMD_RESET;
	int           err_cnt = 0;
	int           idle_pct = 27;
	bit           hold_go = 1'b0;
	bit           stim_done = 1'b0;

	imu_sample_scale_and_frame_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// round a double to single, nearest even; values here stay normal
	function automatic logic [31:0] to_single(real r);
		logic [63:0] b;
		logic [31:0] t;
		b = $realtobits(r);
		if (b[62:0] == '0)
			return {b[63], 31'd0};
		t = {b[63], 8'(b[62:52] - 11'd896), b[51:29]};
		if (b[28] && (b[27:0] != '0 || b[29]))
			t = t + 32'd1;
		return t;
	endfunction

	function automatic real to_double(logic [31:0] f);
		if (f[30:0] == '0)
			return 0.0;
		return $bitstoreal({f[31], {3'b000, f[30:23]} + 11'd896, f[22:0], 29'd0});
	endfunction

	function automatic logic [31:0] accel_to_float(logic signed [15:0] s);
		logic [31:0] p;
		p = to_single(real'(s) * 16.0);
		p = to_single(to_double(p) * to_double(ACCEL_GAIN_SGL));
		return to_single(to_double(p) / 32767.0);
	endfunction

	function automatic logic [31:0] rate_to_float(logic signed [15:0] s);
		logic [31:0] p;
		p = to_single(real'(s) * 2000.0);
		return to_single(to_double(p) / 32767.0);
	endfunction

	function automatic logic [31:0] angle_to_float(logic signed [15:0] s);
		return to_single((real'(s) * 3.14) / 32767.0);
	endfunction

	// raw order: accel x,y,z, rate x,y,z, angle x,y,z
	task automatic predict_frame(reading_t raw);
		logic [7:0]  fb [80];
		logic [31:0] slot [NUM_LANES];
		logic [7:0]  sum;
		frame_word_t fw;
		slot[0] = rate_to_float(raw[5]);
		slot[1] = rate_to_float(raw[3]);
		slot[2] = rate_to_float(raw[4]);
		slot[3] = angle_to_float(raw[8]);
		slot[4] = angle_to_float(raw[6]);
		slot[5] = angle_to_float(raw[7]);
		slot[6] = accel_to_float(raw[1]);
		slot[7] = accel_to_float(raw[0]);
		slot[8] = accel_to_float(raw[2]);
		foreach (fb[i])
			fb[i] = 8'h00;
		fb[0] = HDR0;
		fb[1] = HDR1;
		fb[3] = cmd_model;
		for (int k = 0; k < NUM_LANES; k++)
			for (int b = 0; b < 4; b++)
				fb[4 + 4 * k + b] = slot[k][8 * b +: 8];
		fb[76] = TRL0;
		fb[77] = TRL1;
		fb[78] = TRL2;
		fb[79] = TRL3;
		sum = 8'h00;
		for (int i = 3; i < 76; i++)
			sum = sum + fb[i];
		fb[2] = sum;
		for (int w = 0; w < FRAME_WORDS; w++) begin
			fw.word = {fb[4 * w + 3], fb[4 * w + 2], fb[4 * w + 1], fb[4 * w]};
			fw.idx  = 5'(w);
			fw.last = (w == FRAME_WORDS - 1);
			frame_q.push_back(fw);
		end
	endtask

	// all-zero readings give a frame of header, command, checksum = command, trailer
	task automatic expect_zero_frame();
		frame_word_t fw;
		for (int w = 0; w < FRAME_WORDS; w++) begin
			fw.idx  = 5'(w);
			fw.last = (w == FRAME_WORDS - 1);
			if (w == 0)
				fw.word = {cmd_model, cmd_model, HDR1, HDR0};
			else if (w == FRAME_WORDS - 1)
				fw.word = {TRL3, TRL2, TRL1, TRL0};
			else
				fw.word = 32'h0;
			frame_q.push_back(fw);
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic send_readings(reading_t raw, bit zero_frame);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		for (int i = 0; i < NUM_LANES; i++)
			s_tdata[16 * i +: 16] <= raw[i];
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (zero_frame)
			expect_zero_frame();
		else
			predict_frame(raw);
	endtask

	task automatic drain_and_write(logic [7:0] cmd);
		s_tvalid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= cmd;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cmd_model = cmd;
	endtask

	function automatic logic signed [15:0] pick_reading();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($signed($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver side: random stalls, one long hold-off on request
	initial begin
		int hold_cnt;
		bit hold_done;
		hold_cnt  = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt  = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// output checker
	always @(posedge clk) begin
		frame_word_t want;
		if (m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				$display("%0t unexpected output transaction %h", $realtime, m_tdata);
				err_cnt++;
			end else begin
				want = frame_q.pop_front();
				if (m_tdata[31:0] !== want.word)
					report_mismatch("frame_word", m_tdata[31:0], want.word);
				if (m_tdata[36:32] !== want.idx)
					report_mismatch("word_index", 32'(m_tdata[36:32]), 32'(want.idx));
				if (m_tdata[39:37] !== 3'b000)
					report_mismatch("zero fill", 32'(m_tdata[39:37]), 32'h0);
				if (m_tlast !== want.last)
					report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || stim_done)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t      rows [$];
		stim_row_t      row;
		reading_t       raw;
		logic [7:0]     cmd_plan [5];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (raw[i]) raw[i] = 16'sd0;
		row.raw = raw; row.zero_frame = 1'b1; rows.push_back(row);
		row.zero_frame = 1'b0;
		foreach (raw[i]) raw[i] = 16'sh7FFF;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = 16'sh8000;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = -16'sd1;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = 16'sd1;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = (i % 2) ? 16'sh7FFF : 16'sh8000;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = 16'(i * 1000 - 4000);
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = 16'sh5555;
		row.raw = raw; rows.push_back(row);
		foreach (raw[i]) raw[i] = 16'shAAAA;
		row.raw = raw; rows.push_back(row);
		for (int lane = 0; lane < NUM_LANES; lane++) begin
			foreach (raw[i]) raw[i] = 16'sd0;
			raw[lane] = 16'sd32767;
			row.raw = raw; rows.push_back(row);
		end
		foreach (rows[r])
			send_readings(rows[r].raw, rows[r].zero_frame);

		drain_and_write(8'h00);
		foreach (raw[i]) raw[i] = 16'sd0;
		send_readings(raw, 1'b1);
		drain_and_write(8'hFF);
		send_readings(raw, 1'b1);

		cmd_plan = '{8'hFF, 8'h00, 8'(CMD_RESET), 8'($urandom), 8'hFF};
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_write(cmd_plan[ph]);
			idle_pct = (ph == 1) ? 0 : 27;
			if (ph == 2)
				hold_go = 1'b1;
			for (int n = 0; n < 76; n++) begin
				foreach (raw[i]) raw[i] = pick_reading();
				send_readings(raw, 1'b0);
			end
		end
		s_tvalid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		stim_done = 1'b1;
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
